/* src/wis_pkg.sv */
// ----------------------------------------------------------------------------
// wis_pkg
// Shared types and constants of the weighted index sampler: transaction
// structs, command record, function and status codes, sequencer states.
// ----------------------------------------------------------------------------
package wis_pkg;

  localparam int ENTRIES     = 1024;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 42;
  localparam int WEIGHT_W    = 32;
  localparam int FRAC_W      = 32;
  localparam int HALF_W      = FRAC_W / 2;
  localparam int PROD_W      = DATA_W + HALF_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int RANGE_W     = 11;
  localparam int OUT_IDX_W   = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    FUNC_APPEND       = 2'd0,
    FUNC_SAMPLE_ALL   = 2'd1,
    FUNC_SAMPLE_RANGE = 2'd2,
    FUNC_CLEAR        = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    CMD_RESULT = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_TOP,
    ST_RD_BASE,
    ST_BASE,
    ST_SPAN,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ACC,
    ST_TARGET,
    ST_PROBE,
    ST_CMP,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [WEIGHT_W-1:0] weight;
    logic [RANGE_W-1:0]  range_from;
    logic [RANGE_W-1:0]  range_to;
    logic [FRAC_W-1:0]   random_fraction;
  } request_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] chosen_index;
    logic [DATA_W-1:0]    total_weight;
    logic [1:0]           status;
  } result_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    logic [DATA_W-1:0]  data;
    logic [FRAC_W-1:0]  frac;
    logic [1:0]         status;
  } cmd_t;

endpackage

/* src/weighted_index_sampler.sv */
// Append, clear and rejected requests go from ST_IDLE straight to ST_EMIT. A sample
// passes ST_RD_TOP through ST_TARGET, then one ST_PROBE and ST_CMP pair per search
// probe, because the cumulative table has one registered read port.
// The back end runs one command at a time; the command queue holds up to four more.
// Reset (rst, synchronous) empties the table, zeroes the total and drops all queued work.
// ----------------------------------------------------------------------------
// weighted_index_sampler
// Weighted random index picker based on an inverse cumulative distribution:
// appends build a table of running sums, samples scale a random fraction
// across a range of it and binary-search for the chosen index.
// ----------------------------------------------------------------------------
module weighted_index_sampler (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  wis_pkg::request_t request,
  output logic              empty,
  input  logic              pop,
  output wis_pkg::result_t  result
);
  import wis_pkg::*;

  // The front end owns the entry count and running total. Both depend only
  // on the sequence of requests, so every check (full table, empty table,
  // bad subrange) and every append sum is settled the moment a transaction
  // is accepted, and the result fields are known except for the searched
  // index.
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  wis_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .q_push  (q_push),
    .q_full  (q_full),
    .cmd     (front_cmd)
  );

  // The command queue lets the front keep accepting transactions while the
  // back end is busy with a long search or waits for its result to be taken.
  wis_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (back_cmd),
    .empty     (q_empty)
  );

  // The back end alone touches the cumulative table, in command order, so a
  // sample never sees an append or a clear that was accepted after it. Its
  // result register is the head of the result queue seen on the ports.
  wis_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cmd     (back_cmd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

/* src/wis_ram.sv */
// ----------------------------------------------------------------------------
// wis_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/wis_front.sv */
// ----------------------------------------------------------------------------
// wis_front
// Accepts request transactions, tracks entry count and running total, and
// turns each request into a command for the back end.
// ----------------------------------------------------------------------------
module wis_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  wis_pkg::request_t request,
  output logic              q_push,
  input  logic              q_full,
  output wis_pkg::cmd_t     cmd
);
  import wis_pkg::*;

  logic [CNT_W-1:0]  count, count_next;
  logic [DATA_W-1:0] total, total_next;
  logic [DATA_W:0]   sum_wide;
  logic [DATA_W-1:0] sum_sat;
  logic [CNT_W-1:0]  to_minus_one;
  logic              range_bad;

  assign full   = q_full;
  assign q_push = push && !q_full;

  assign sum_wide = {1'b0, total} + {{(DATA_W + 1 - WEIGHT_W){1'b0}}, request.weight};
  assign sum_sat  = sum_wide[DATA_W] ? {DATA_W{1'b1}} : sum_wide[DATA_W-1:0];

  assign to_minus_one = request.range_to - CNT_W'(1);
  assign range_bad    = (request.range_to == '0) ||
                        (request.range_from >= request.range_to) ||
                        (request.range_to > count);

  always_comb begin
    count_next = count;
    total_next = total;
    cmd.kind   = CMD_RESULT;
    cmd.idx    = '0;
    cmd.lo     = '0;
    cmd.hi     = '0;
    cmd.data   = total;
    cmd.frac   = request.random_fraction;
    cmd.status = STATUS_OK;
    unique case (func_e_t'(request.func))
      FUNC_APPEND: begin
        if (count >= CNT_W'(ENTRIES)) begin
          cmd.status = STATUS_FULL;
        end else begin
          cmd.kind   = CMD_WRITE;
          cmd.idx    = count[IDX_W-1:0];
          cmd.data   = sum_sat;
          count_next = count + CNT_W'(1);
          total_next = sum_sat;
        end
      end
      FUNC_SAMPLE_ALL: begin
        if (count == '0) begin
          cmd.status = STATUS_EMPTY;
        end else begin
          cmd.kind = CMD_SEARCH;
          cmd.hi   = IDX_W'(count - CNT_W'(1));
        end
      end
      FUNC_SAMPLE_RANGE: begin
        if (range_bad) begin
          cmd.status = STATUS_EMPTY;
        end else begin
          cmd.kind = CMD_SEARCH;
          cmd.lo   = request.range_from[IDX_W-1:0];
          cmd.hi   = to_minus_one[IDX_W-1:0];
        end
      end
      FUNC_CLEAR: begin
        count_next = '0;
        total_next = '0;
        cmd.data   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (q_push) begin
      count <= count_next;
      total <= total_next;
    end
  end

endmodule

/* src/wis_queue.sv */
// ----------------------------------------------------------------------------
// wis_queue
// Small command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module wis_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wis_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output wis_pkg::cmd_t pop_data,
  output logic          empty
);
  import wis_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full     = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

/* src/wis_back.sv */
// ----------------------------------------------------------------------------
// wis_back
// Executes commands: writes appended sums into the cumulative table, and for
// samples reads the range bounds, scales the random fraction with a shared
// 42x16 multiplier and binary-searches the table. Holds the result register.
// ----------------------------------------------------------------------------
module wis_back (
  input  logic             clk,
  input  logic             rst,
  input  wis_pkg::cmd_t    cmd,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output wis_pkg::result_t result
);
  import wis_pkg::*;

  back_state_t       state, state_next;
  result_t           work;
  result_t           out_r;
  logic              out_valid;
  logic [FRAC_W-1:0] frac_r;
  logic [IDX_W-1:0]  lo_s, hi_s, mid_r;
  logic [DATA_W-1:0] top_r, base_r, span_r, target;
  logic [PROD_W-1:0] prod_hi, prod_lo, mul_res;
  logic [ACC_W-1:0]  acc_r;
  logic [HALF_W-1:0] mul_op;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid;
  logic              emit_fire;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  wis_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.idx),
    .wdata (cmd.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mid_sum   = {1'b0, lo_s} + {1'b0, hi_s};
  assign mid       = mid_sum[IDX_W:1];
  assign mul_op    = (state == ST_MUL_HI) ? frac_r[FRAC_W-1:HALF_W] : frac_r[HALF_W-1:0];
  assign mul_res   = {{HALF_W{1'b0}}, span_r} * {{DATA_W{1'b0}}, mul_op};
  assign emit_fire = (state == ST_EMIT) && (!out_valid || pop);
  assign empty     = !out_valid;
  assign result    = out_r;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = (cmd.kind == CMD_SEARCH) ? ST_RD_TOP : ST_EMIT;
        end
      end
      ST_RD_TOP:  state_next = ST_RD_BASE;
      ST_RD_BASE: state_next = ST_BASE;
      ST_BASE:    state_next = ST_SPAN;
      ST_SPAN:    state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_MUL_LO;
      ST_MUL_LO:  state_next = ST_ACC;
      ST_ACC:     state_next = ST_TARGET;
      ST_TARGET:  state_next = ST_PROBE;
      ST_PROBE:   state_next = (hi_s > lo_s) ? ST_CMP : ST_EMIT;
      ST_CMP:     state_next = ST_PROBE;
      ST_EMIT: begin
        if (!out_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs to the queue and the table.
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = mid;
    unique case (state)
      ST_IDLE: begin
        q_pop  = !q_empty;
        ram_we = !q_empty && (cmd.kind == CMD_WRITE);
      end
      ST_RD_TOP:  ram_raddr = hi_s;
      ST_RD_BASE: ram_raddr = lo_s - IDX_W'(1);
      default:    ram_raddr = mid;
    endcase
  end

  // The table read data is registered, so the top sum arrives
  // in ST_RD_BASE and the base sum in ST_BASE.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        work.chosen_index <= OUT_IDX_W'(cmd.idx);
        work.total_weight <= cmd.data;
        work.status       <= cmd.status;
        frac_r            <= cmd.frac;
        lo_s              <= cmd.lo;
        hi_s              <= cmd.hi;
      end
      ST_RD_BASE: top_r <= ram_rdata;
      ST_BASE: begin
        base_r <= (lo_s == '0) ? '0 : ram_rdata;
        span_r <= (lo_s == '0) ? top_r :
                  ((top_r >= ram_rdata) ? (top_r - ram_rdata) : '0);
      end
      ST_MUL_HI: prod_hi <= mul_res;
      ST_MUL_LO: prod_lo <= mul_res;
      ST_ACC:    acc_r   <= {1'b0, prod_hi} + {{(HALF_W + 1){1'b0}}, prod_lo[PROD_W-1:HALF_W]};
      ST_TARGET: target  <= base_r + acc_r[PROD_W-1:HALF_W];
      ST_PROBE: begin
        mid_r <= mid;
        if (hi_s <= lo_s) begin
          work.chosen_index <= OUT_IDX_W'(lo_s);
        end
      end
      ST_CMP: begin
        if (target < ram_rdata) begin
          hi_s <= mid_r;
        end else begin
          lo_s <= mid_r + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (emit_fire) begin
      out_r <= work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/wis_checker.sv */
// ----------------------------------------------------------------------------
// wis_port_checks
// Port-level checks for the weighted index sampler, bound to the top level.
// ----------------------------------------------------------------------------
module wis_port_checks (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input wis_pkg::result_t  result
);
  import wis_pkg::*;

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered right after reset");

  // The input side is open in the cycle after reset.
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked right after reset");

  // A waiting result holds until it is popped.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // Status is always one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.status == STATUS_OK || result.status == STATUS_FULL ||
                result.status == STATUS_EMPTY))
    else $error("undefined status code");

  // Any error result reports index zero.
  a_error_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != STATUS_OK) |-> (result.chosen_index == '0))
    else $error("error result with nonzero index");

endmodule

bind weighted_index_sampler wis_port_checks u_wis_port_checks (
  .clk     (clk),
  .rst     (rst),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .result  (result)
);

/* sim/wis_checker.sv */
// ----------------------------------------------------------------------------
// wis_checker
// Watches both queue sides of the weighted index sampler. It keeps its own
// copy of the cumulative weight table and predicts every result, then
// compares each popped result with the oldest prediction.
// ----------------------------------------------------------------------------
module wis_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  wis_pkg::request_t request,
  input  logic              empty,
  input  logic              pop,
  input  wis_pkg::result_t  result,
  output int                fail_count,
  output int                picks_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import wis_pkg::*;

  logic [DATA_W-1:0] cum_table [0:ENTRIES-1];
  int                n_entries;
  logic [DATA_W-1:0] grand_total;
  result_t           predicted_picks [$];

  // floor(span * u / 2^32), exact through a full-width product.
  function automatic logic [DATA_W-1:0] scale_fraction(logic [DATA_W-1:0] span,
                                                       logic [FRAC_W-1:0] u);
    logic [DATA_W+FRAC_W-1:0] prod;
    prod = (DATA_W + FRAC_W)'(span) * (DATA_W + FRAC_W)'(u);
    return prod[DATA_W+FRAC_W-1:FRAC_W];
  endfunction

  // Lowest index in [lo, hi] whose running sum exceeds target, else hi.
  function automatic int first_above(int lo, int hi, logic [DATA_W-1:0] target);
    int mid;
    while (hi > lo) begin
      mid = (lo + hi) / 2;
      if (target < cum_table[mid]) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  task automatic apply_request(input request_t r, output result_t res);
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] span;
    int                pick;
    res = '0;
    res.status = STATUS_OK;
    case (r.func)
      FUNC_APPEND: begin
        if (n_entries >= ENTRIES) begin
          res.status = STATUS_FULL;
        end else begin
          sum = {1'b0, grand_total} + {{(DATA_W + 1 - WEIGHT_W){1'b0}}, r.weight};
          grand_total = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
          cum_table[n_entries] = grand_total;
          res.chosen_index = OUT_IDX_W'(n_entries);
          n_entries++;
        end
      end
      FUNC_SAMPLE_ALL: begin
        if (n_entries == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          pick = first_above(0, n_entries - 1,
                             scale_fraction(grand_total, r.random_fraction));
          res.chosen_index = OUT_IDX_W'(pick);
        end
      end
      FUNC_SAMPLE_RANGE: begin
        if (r.range_to == 0 || r.range_from >= r.range_to || r.range_to > n_entries) begin
          res.status = STATUS_EMPTY;
        end else begin
          base = (r.range_from == 0) ? '0 : cum_table[r.range_from - 1];
          top  = cum_table[r.range_to - 1];
          span = (top >= base) ? top - base : '0;
          pick = first_above(r.range_from, r.range_to - 1,
                             base + scale_fraction(span, r.random_fraction));
          res.chosen_index = OUT_IDX_W'(pick);
        end
      end
      default: begin
        n_entries   = 0;
        grand_total = '0;
      end
    endcase
    res.total_weight = grand_total;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      n_entries   = 0;
      grand_total = '0;
      fail_count  = 0;
      predicted_picks.delete();
    end else begin
      if (push && !full) begin
        apply_request(request, want);
        predicted_picks.push_back(want);
      end
      if (pop && !empty) begin
        if (predicted_picks.size() == 0) begin
          $error("result transaction arrived with no prediction pending");
          fail_count++;
        end else begin
          want = predicted_picks.pop_front();
          if (result.chosen_index !== want.chosen_index) begin
            $error("chosen_index: expected %0d, actual %0d",
                   want.chosen_index, result.chosen_index);
            fail_count++;
          end
          if (result.total_weight !== want.total_weight) begin
            $error("total_weight: expected %0d, actual %0d",
                   want.total_weight, result.total_weight);
            fail_count++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            fail_count++;
          end
        end
      end
    end
    picks_owed = predicted_picks.size();
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the weighted index sampler. A directed opening
// covers empty tables, zero weights and bad subranges; random episodes then
// mix appends, samples and clears, with random idle bursts on both queue
// sides. Checking is done by wis_checker, instantiated next to the sampler.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wis_pkg::*;

  // Cycles with no accepted transaction on either side before giving up.
  // This leaves a wide margin over the slowest sample and the longest idle
  // burst of either side.
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 380;

  logic     clk;
  logic     rst;
  logic     push;
  logic     full;
  request_t request;
  logic     empty;
  logic     pop;
  result_t  result;

  int fail_count;
  int picks_owed;
  int idle_cycles;

  // Number of table entries the stimulus believes are filled. It only
  // shapes the subranges that get drawn; predictions live in the checker.
  int fill;

  // Once set, neither side idles any more, so the tail runs at full rate.
  bit quiet;

  // Stretch of upcoming items that the sender sends back to back.
  int sender_calm;

  weighted_index_sampler DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .request(request),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  wis_checker sampler_check (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .fail_count(fail_count),
    .picks_owed(picks_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Random 32-bit word that hits zero and all ones often, small values
  // sometimes, and anything else the rest of the time.
  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Sends one request transaction. It is called at a falling edge and
  // returns at the falling edge after the transaction was accepted, with
  // push still high, so back-to-back items never drop push in between.
  task automatic send_item(input func_e_t f, input logic [31:0] w,
                           input int lo, input int hi,
                           input logic [31:0] u);
    request_t r;
    r.func            = f;
    r.weight          = w;
    r.range_from      = RANGE_W'(lo);
    r.range_to        = RANGE_W'(hi);
    r.random_fraction = u;
    if (!quiet) begin
      if (sender_calm > 0) begin
        sender_calm--;
      end else if ($urandom_range(0, 19) == 0) begin
        sender_calm = $urandom_range(10, 40);
      end else if ($urandom_range(0, 2) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
    end
    push    <= 1'b1;
    request <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    if (f == FUNC_APPEND && fill < ENTRIES) fill++;
    if (f == FUNC_CLEAR) fill = 0;
    @(negedge clk);
  endtask

  // Subrange sample: mostly a legal range inside the filled part of the
  // table, sometimes arbitrary 11-bit bounds that are usually rejected.
  task automatic send_random_range();
    int lo;
    int hi;
    if (fill > 0 && $urandom_range(0, 7) != 0) begin
      hi = $urandom_range(1, fill);
      lo = $urandom_range(0, hi - 1);
    end else begin
      lo = $urandom_range(0, 2047);
      hi = $urandom_range(0, 2047);
    end
    send_item(FUNC_SAMPLE_RANGE, $urandom, lo, hi, draw_word());
  endtask

  // Result side: pop stays high most of the time, drops for random bursts,
  // and now and then holds high for a long stretch.
  initial begin : result_side
    int stall;
    int calm;
    pop   = 1'b0;
    stall = 0;
    calm  = 0;
    forever begin
      @(negedge clk);
      if (rst || stall > 0) begin
        pop <= 1'b0;
        if (stall > 0) stall--;
      end else begin
        if (!quiet && calm > 0) calm--;
        if (quiet || calm > 0) begin
          pop <= 1'b1;
        end else if ($urandom_range(0, 49) == 0) begin
          calm = $urandom_range(20, 80);
          pop <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
          stall = $urandom_range(1, 17) - 1;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction is accepted on either
  // side and stops the run if the sampler seems hung.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int pick;
    rst         = 1'b1;
    push        = 1'b0;
    request     = '0;
    quiet       = 1'b0;
    fill        = 0;
    sender_calm = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening. An empty table rejects both kinds of sample, and a
    // clear on an empty table is harmless.
    send_item(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
    send_item(FUNC_SAMPLE_ALL, $urandom, 0, 0, $urandom);
    send_item(FUNC_SAMPLE_RANGE, $urandom, 0, 1, $urandom);
    // Only zero weights: no entry lies above the target, so the search
    // must land on the last index of the range.
    send_item(FUNC_APPEND, '0, $urandom, $urandom, $urandom);
    send_item(FUNC_APPEND, '0, $urandom, $urandom, $urandom);
    send_item(FUNC_SAMPLE_ALL, $urandom, $urandom, $urandom, '1);
    send_item(FUNC_SAMPLE_RANGE, $urandom, 0, 2, '0);
    // Largest weights next to a small one, sampled at both fraction ends.
    send_item(FUNC_APPEND, '1, $urandom, $urandom, $urandom);
    send_item(FUNC_APPEND, 32'd5, $urandom, $urandom, $urandom);
    send_item(FUNC_APPEND, '1, $urandom, $urandom, $urandom);
    send_item(FUNC_SAMPLE_ALL, $urandom, $urandom, $urandom, '0);
    send_item(FUNC_SAMPLE_ALL, $urandom, $urandom, $urandom, '1);
    send_item(FUNC_SAMPLE_RANGE, $urandom, 0, 5, '1);
    send_item(FUNC_SAMPLE_RANGE, $urandom, 2, 3, $urandom);
    send_item(FUNC_SAMPLE_RANGE, $urandom, 3, 5, 32'h8000_0000);
    // Bad subranges: end at zero, empty range, reversed bounds, end past
    // the filled part, and both bounds with every bit set.
    send_item(FUNC_SAMPLE_RANGE, $urandom, 0, 0, $urandom);
    send_item(FUNC_SAMPLE_RANGE, $urandom, 4, 4, $urandom);
    send_item(FUNC_SAMPLE_RANGE, $urandom, 5, 3, $urandom);
    send_item(FUNC_SAMPLE_RANGE, $urandom, 0, 6, $urandom);
    send_item(FUNC_SAMPLE_RANGE, $urandom, 2047, 2047, $urandom);
    send_item(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
    send_item(FUNC_SAMPLE_ALL, $urandom, $urandom, $urandom, $urandom);

    // Let the sampler drain completely before the random part starts.
    push <= 1'b0;
    @(negedge clk);
    while (picks_owed != 0) @(negedge clk);

    // Random part. Appends outnumber clears by about ten to one, so the
    // table grows to about ten entries between clears on average, and most
    // samples fall on a legal range of what is there.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - 60) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_item(FUNC_APPEND, draw_word(), $urandom, $urandom, $urandom);
      end else if (pick < 62) begin
        send_item(FUNC_SAMPLE_ALL, $urandom, $urandom, $urandom, draw_word());
      end else if (pick < 96) begin
        send_random_range();
      end else begin
        send_item(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end
    end

    // Wait for the last results, then allow for the longest sample latency.
    push <= 1'b0;
    while (picks_owed != 0) @(negedge clk);
    repeat (48) @(negedge clk);

    if (fail_count == 0 && picks_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
